FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FSI_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FSI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/fsi_pkg.sv
// ----------------------------------------------------------------------------
// fsi_pkg
// Types and constants shared by the fragment seek index modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fsi_pkg;

  localparam int unsigned ENTRIES_W = 11;  // entries_in_use register
  localparam int unsigned TRACKS_W  = 4;   // tracks_in_use register
  localparam int unsigned ENTRY_W   = 10;  // entry_index field
  localparam int unsigned TRACK_W   = 3;   // track_index field
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned Q_DEPTH   = 2;   // request queue depth, power of two

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_TIME  = 3'd0,
    MODE_WR_POS   = 3'd1,
    MODE_SEEK     = 3'd2,
    MODE_START    = 3'd3,
    MODE_DURATION = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRIES  = 2'd0,
    CFG_TRACKS   = 2'd1,
    CFG_END_TIME = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_FAIL    = 3'd0,
    CMD_WR_TIME = 3'd1,
    CMD_WR_POS  = 3'd2,
    CMD_SEEK    = 3'd3,
    CMD_START   = 3'd4,
    CMD_DUR     = 3'd5
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_SCAN   = 3'd2,
    ST_FETCH  = 3'd3,
    ST_WAIT   = 3'd4
  } back_state_t;

  // Saturated configuration as seen by the front end
  typedef struct packed {
    logic [ENTRIES_W-1:0] n;
    logic [TRACKS_W-1:0]  nt;
    logic [DATA_W-1:0]    end_time;
  } live_cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_kind_t            kind;
    logic [ENTRIES_W-1:0] n;
    logic [ENTRY_W-1:0]   entry;
    logic [TRACK_W-1:0]   track;
    logic [DATA_W-1:0]    time_val;
    logic [DATA_W-1:0]    pos_val;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fragment_seek_index_top.sv
// Scans: a seek or a start-time query reads the entries in use, one read per cycle.
// Throughput: one request runs in the back end and up to two wait in the queue behind
// it; busy marks a full queue. Results strobe on done for one cycle, taken at once.
// Reset: synchronous, active high; clears control and sets the registers to 1, 1, 0.
// ----------------------------------------------------------------------------
// fragment_seek_index_top
// Fragment seek index: table of fragment positions and per-track start times.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_seek_index_top #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned MAX_TRACKS  = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [fsi_pkg::MODE_W-1:0]            mode,
  input  wire logic [fsi_pkg::ENTRY_W-1:0]           entry_index,
  input  wire logic [fsi_pkg::TRACK_W-1:0]           track_index,
  input  wire logic signed [fsi_pkg::DATA_W-1:0]     time_in,
  input  wire logic [fsi_pkg::DATA_W-1:0]            position_in,
  input  wire logic                                  cfg_write,
  input  wire logic [fsi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [fsi_pkg::DATA_W-1:0]            cfg_wdata,
  output logic                                       done,
  output logic                                       found,
  output logic signed [fsi_pkg::DATA_W-1:0]          time_out,
  output logic [fsi_pkg::DATA_W-1:0]                 position_out
);

  localparam int unsigned NW = fsi_pkg::ENTRIES_W;
  localparam int unsigned KW = fsi_pkg::TRACKS_W;

  logic [NW-1:0]                 entries_in_use;
  logic [KW-1:0]                 tracks_in_use;
  logic [fsi_pkg::DATA_W-1:0]    end_time;
  fsi_pkg::live_cfg_t            live;
  fsi_pkg::cmd_t                 cmd;
  fsi_pkg::cmd_t                 head;
  logic                          push;
  logic                          pop;
  logic                          q_empty;
  logic                          q_full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= NW'(1);
      tracks_in_use  <= KW'(1);
      end_time       <= '0;
    end else if (cfg_write) begin
      case (fsi_pkg::cfg_reg_t'(cfg_index))
        fsi_pkg::CFG_ENTRIES:  entries_in_use <= cfg_wdata[NW-1:0];
        fsi_pkg::CFG_TRACKS:   tracks_in_use  <= cfg_wdata[KW-1:0];
        fsi_pkg::CFG_END_TIME: end_time       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate counts to the table dimensions
  assign live.n  = (32'(entries_in_use) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : entries_in_use;
  assign live.nt = (32'(tracks_in_use) > MAX_TRACKS) ? KW'(MAX_TRACKS) : tracks_in_use;
  assign live.end_time = end_time;

  fsi_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_TRACKS  (MAX_TRACKS)
  ) u_front (
    .start       (start),
    .q_full      (q_full),
    .mode        (mode),
    .entry_index (entry_index),
    .track_index (track_index),
    .time_in     (time_in),
    .position_in (position_in),
    .live        (live),
    .busy        (busy),
    .push        (push),
    .cmd         (cmd)
  );

  fsi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  fsi_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_TRACKS  (MAX_TRACKS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .done         (done),
    .found        (found),
    .time_out     (time_out),
    .position_out (position_out)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/fsi_front.sv
// ----------------------------------------------------------------------------
// fsi_front
// Accepts requests and classifies them into back-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fsi_front #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned MAX_TRACKS  = 8
) (
  input  wire logic                                  start,
  input  wire logic                                  q_full,
  input  wire logic [fsi_pkg::MODE_W-1:0]            mode,
  input  wire logic [fsi_pkg::ENTRY_W-1:0]           entry_index,
  input  wire logic [fsi_pkg::TRACK_W-1:0]           track_index,
  input  wire logic signed [fsi_pkg::DATA_W-1:0]     time_in,
  input  wire logic [fsi_pkg::DATA_W-1:0]            position_in,
  input  wire fsi_pkg::live_cfg_t                    live,
  output logic                                       busy,
  output logic                                       push,
  output fsi_pkg::cmd_t                              cmd
);

  localparam int unsigned TK_W = fsi_pkg::TRACKS_W;

  logic entry_ok;
  logic track_ok;
  logic track_live;

  // Accept whenever the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  assign entry_ok   = 32'(entry_index) < MAX_ENTRIES;
  assign track_ok   = 32'(track_index) < MAX_TRACKS;
  assign track_live = TK_W'(track_index) < live.nt;

  // Classify the request; failing requests collapse to CMD_FAIL
  always_comb begin
    cmd.n        = live.n;
    cmd.entry    = entry_index;
    cmd.track    = track_index;
    cmd.time_val = time_in;
    cmd.pos_val  = position_in;
    cmd.kind     = fsi_pkg::CMD_FAIL;
    case (fsi_pkg::mode_t'(mode))
      fsi_pkg::MODE_WR_TIME: begin
        if (entry_ok && track_ok) cmd.kind = fsi_pkg::CMD_WR_TIME;
      end
      fsi_pkg::MODE_WR_POS: begin
        if (entry_ok) cmd.kind = fsi_pkg::CMD_WR_POS;
      end
      fsi_pkg::MODE_SEEK: begin
        if ((time_in < $signed(live.end_time)) && (live.n != '0) && track_live)
          cmd.kind = fsi_pkg::CMD_SEEK;
      end
      fsi_pkg::MODE_START: begin
        if (track_live && (live.n != '0)) cmd.kind = fsi_pkg::CMD_START;
      end
      fsi_pkg::MODE_DURATION: begin
        if ((live.n != '0) && track_live) cmd.kind = fsi_pkg::CMD_DUR;
      end
      default: cmd.kind = fsi_pkg::CMD_FAIL;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fsi_queue.sv
// ----------------------------------------------------------------------------
// fsi_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fsi_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fsi_pkg::cmd_t  push_data,
  input  wire logic           pop,
  output fsi_pkg::cmd_t       head,
  output logic                empty,
  output logic                full
);

  localparam int unsigned DEPTH = fsi_pkg::Q_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fsi_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (do_pop)  rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      case ({do_push, do_pop})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  // Hold request payload
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  `FSI_ASSERT_IMPLY(a_q_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue overfilled")
  `FSI_ASSERT_NEXT(a_q_fill, do_push && !do_pop, !empty, "queue empty after push")

endmodule

`default_nettype wire

FILE: hw/rtl/fsi_back.sv
// ----------------------------------------------------------------------------
// fsi_back
// Executes commands: table writes, seek and start-time scans, duration reads.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fsi_back #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned MAX_TRACKS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire fsi_pkg::cmd_t                     head,
  input  wire logic                              q_empty,
  output logic                                   pop,
  output logic                                   done,
  output logic                                   found,
  output logic signed [fsi_pkg::DATA_W-1:0]      time_out,
  output logic [fsi_pkg::DATA_W-1:0]             position_out
);

  localparam int unsigned EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned TW     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned TDEPTH = MAX_ENTRIES * (2 ** TW);
  localparam int unsigned NW     = fsi_pkg::ENTRIES_W;
  localparam int unsigned DW     = fsi_pkg::DATA_W;

  // Table storage
  logic [DW-1:0] tmem [TDEPTH];
  logic [DW-1:0] pmem [MAX_ENTRIES];

  fsi_pkg::back_state_t state, state_next;
  fsi_pkg::cmd_t        cur, cur_next;
  logic [NW-1:0]        issue_idx, issue_idx_next;
  logic [NW-1:0]        rd_idx, rd_idx_next;
  logic                 rd_pend, rd_pend_next;
  logic [EW-1:0]        pick, pick_next;
  logic [DW-1:0]        tdata;
  logic [DW-1:0]        pdata;
  logic                 done_next, found_next;
  logic [DW-1:0]        tout_next, pout_next;
  logic [DW-1:0]        tout_r;

  logic                 t_we, t_re, p_we, p_re;
  logic [TW-1:0]        trk;
  logic [EW+TW-1:0]     t_waddr, t_raddr;
  logic [EW-1:0]        p_raddr;
  logic                 is_seek;
  logic                 hit;

  assign trk      = TW'(cur.track);
  assign t_waddr  = {EW'(cur.entry), trk};
  assign is_seek  = (cur.kind == fsi_pkg::CMD_SEEK);
  assign time_out = tout_r;

  // Seek stops at the first later time; start-time stops at the first position at or past
  assign hit = is_seek ? ($signed(tdata) > $signed(cur.time_val)) : (pdata >= cur.pos_val);

  // Next state and datapath control
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    issue_idx_next = issue_idx;
    rd_idx_next    = rd_idx;
    rd_pend_next   = rd_pend;
    pick_next      = pick;
    done_next      = 1'b0;
    found_next     = found;
    tout_next      = tout_r;
    pout_next      = position_out;
    pop            = 1'b0;
    t_we           = 1'b0;
    p_we           = 1'b0;
    t_re           = 1'b0;
    p_re           = 1'b0;
    t_raddr        = {EW'(issue_idx), trk};
    p_raddr        = EW'(issue_idx);
    case (state)
      fsi_pkg::ST_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          cur_next   = head;
          state_next = fsi_pkg::ST_DECODE;
        end
      end
      fsi_pkg::ST_DECODE: begin
        rd_pend_next = 1'b0;
        case (cur.kind)
          fsi_pkg::CMD_WR_TIME: begin
            t_we       = 1'b1;
            done_next  = 1'b1;
            found_next = 1'b1;
            tout_next  = '0;
            pout_next  = '0;
            state_next = fsi_pkg::ST_IDLE;
          end
          fsi_pkg::CMD_WR_POS: begin
            p_we       = 1'b1;
            done_next  = 1'b1;
            found_next = 1'b1;
            tout_next  = '0;
            pout_next  = '0;
            state_next = fsi_pkg::ST_IDLE;
          end
          fsi_pkg::CMD_SEEK: begin
            issue_idx_next = NW'(1);
            state_next     = fsi_pkg::ST_SCAN;
          end
          fsi_pkg::CMD_START: begin
            issue_idx_next = '0;
            state_next     = fsi_pkg::ST_SCAN;
          end
          fsi_pkg::CMD_DUR: begin
            pick_next  = EW'(cur.n - 1'b1);
            state_next = fsi_pkg::ST_FETCH;
          end
          default: begin
            done_next  = 1'b1;
            found_next = 1'b0;
            tout_next  = '0;
            pout_next  = '0;
            state_next = fsi_pkg::ST_IDLE;
          end
        endcase
      end
      fsi_pkg::ST_SCAN: begin
        if (rd_pend && hit) begin
          // Seek takes the entry before the first later one
          pick_next  = is_seek ? EW'(rd_idx - 1'b1) : EW'(rd_idx);
          state_next = fsi_pkg::ST_FETCH;
        end else if (issue_idx >= cur.n) begin
          if (is_seek) begin
            // Fall back to the last entry in use on the queried track
            pick_next  = EW'(cur.n - 1'b1);
            state_next = fsi_pkg::ST_FETCH;
          end else begin
            done_next  = 1'b1;
            found_next = 1'b0;
            tout_next  = '0;
            pout_next  = '0;
            state_next = fsi_pkg::ST_IDLE;
          end
        end else begin
          // Issue the next entry read; its data is checked next cycle
          t_re           = is_seek;
          p_re           = !is_seek;
          rd_idx_next    = issue_idx;
          rd_pend_next   = 1'b1;
          issue_idx_next = NW'(issue_idx + 1'b1);
        end
      end
      fsi_pkg::ST_FETCH: begin
        t_re       = 1'b1;
        p_re       = 1'b1;
        t_raddr    = {pick, trk};
        p_raddr    = pick;
        state_next = fsi_pkg::ST_WAIT;
      end
      fsi_pkg::ST_WAIT: begin
        done_next  = 1'b1;
        found_next = 1'b1;
        tout_next  = tdata;
        pout_next  = is_seek ? pdata : '0;
        state_next = fsi_pkg::ST_IDLE;
      end
      default: state_next = fsi_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fsi_pkg::ST_IDLE;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
      done    <= done_next;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    cur          <= cur_next;
    issue_idx    <= issue_idx_next;
    rd_idx       <= rd_idx_next;
    pick         <= pick_next;
    found        <= found_next;
    tout_r       <= tout_next;
    position_out <= pout_next;
  end

  // Time table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (t_we) tmem[t_waddr] <= cur.time_val;
    if (t_re) tdata <= tmem[t_raddr];
  end

  // Position table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (p_we) pmem[EW'(cur.entry)] <= cur.pos_val;
    if (p_re) pdata <= pmem[p_raddr];
  end

  `FSI_ASSERT_NEXT(a_done_source, state == fsi_pkg::ST_IDLE || state == fsi_pkg::ST_FETCH, !done, "result strobe from idle or fetch")
  `FSI_ASSERT_IMPLY(a_scan_bound, state == fsi_pkg::ST_SCAN, issue_idx <= cur.n, "scan ran past entries in use")
  `FSI_ASSERT_IMPLY(a_scan_pipe, state == fsi_pkg::ST_SCAN && rd_pend, NW'(rd_idx + 1'b1) == issue_idx, "scan read out of step")

endmodule

`default_nettype wire
